[rtl/core/length_xor_frame_deframer_defines.svh]
// Assertion macros for the deframer RTL.
`ifndef LENGTH_XOR_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_XOR_FRAME_DEFRAMER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define LXD_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("deframer check failed in the same cycle");

// The condition must hold in the cycle after the trigger.
`define LXD_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("deframer check failed one cycle later");

`endif

[rtl/core/lxd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lxd_pkg;

   // Frame geometry.
   localparam int MAX_DATA_BYTES = 8;
   localparam int MIN_FRAME_LEN  = 4;
   localparam int MAX_FRAME_LEN  = MAX_DATA_BYTES + MIN_FRAME_LEN;
   localparam int LEN_W          = $clog2(MAX_FRAME_LEN + 1);
   localparam int BYTE_W         = 8;
   localparam int ID_W           = 16;
   localparam int DLEN_W         = 4;
   localparam int PAYLOAD_W      = 64;
   localparam int LANES          = PAYLOAD_W / BYTE_W;
   localparam int ID_LAST_POS    = 2;
   localparam int DATA_FIRST_POS = 3;

   typedef logic [LEN_W-1:0] len_type;

   typedef enum logic [1:0] {
      STATUS_GOOD = 2'd0,
      STATUS_CSUM = 2'd1,
      STATUS_LEN  = 2'd2
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              burst_start;
   } req_type;

   typedef struct packed {
      logic    valid;
      req_type data;
   } req_beat_type;

   typedef struct packed {
      status_type           status;
      logic [ID_W-1:0]      can_id;
      logic [DLEN_W-1:0]    data_len;
      logic [PAYLOAD_W-1:0] payload;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } rsp_beat_type;

endpackage
`default_nettype wire

[rtl/core/lxd_channels.sv]
`timescale 1ns / 1ps
`default_nettype none
// Received byte channel.
interface lxd_req_if import lxd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              burst_start;

   modport source (output valid, rx_byte, burst_start, input ready);
   modport sink   (input valid, rx_byte, burst_start, output ready);
endinterface

// Frame result channel.
interface lxd_rsp_if import lxd_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [ID_W-1:0]      can_id;
   logic [DLEN_W-1:0]    data_len;
   logic [PAYLOAD_W-1:0] payload;

   modport source (output valid, status, can_id, data_len, payload, input ready);
   modport sink   (input valid, status, can_id, data_len, payload, output ready);
endinterface
`default_nettype wire

[rtl/core/lxd_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
module lxd_in_reg import lxd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire req_type      req_data,
   output logic              req_ready,
   input  wire logic         advance,
   output req_beat_type      beat
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   // The register takes a new item when empty or when its item moves on.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_data;
      end
   end

   assign beat.valid = valid_ff;
   assign beat.data  = data_ff;

endmodule
`default_nettype wire

[rtl/core/lxd_frame_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
module lxd_frame_engine import lxd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_beat_type beat,
   input  wire logic         advance,
   output rsp_beat_type      result
);

   len_type              pos_ff;
   len_type              pos_in;
   len_type              len_ff;
   len_type              len_in;
   logic [BYTE_W-1:0]    xor_ff;
   logic [BYTE_W-1:0]    xor_in;
   logic [ID_W-1:0]      id_ff;
   logic [ID_W-1:0]      id_in;
   logic [PAYLOAD_W-1:0] data_ff;
   logic [PAYLOAD_W-1:0] data_in;

   logic              fire;
   logic [BYTE_W-1:0] rx;
   len_type           pos_eff;
   logic              len_bad;
   logic              last_byte;
   len_type           dlen_full;

   assign fire = beat.valid && advance;
   assign rx   = beat.data.rx_byte;

   // A burst start drops the partial frame and looks for a length byte.
   assign pos_eff = beat.data.burst_start ? '0 : pos_ff;

   assign len_bad = (rx < BYTE_W'(MIN_FRAME_LEN)) || (rx > BYTE_W'(MAX_FRAME_LEN));
   assign last_byte = ({1'b0, pos_ff} + (LEN_W + 1)'(1)) >= {1'b0, len_ff};
   assign dlen_full = len_ff - LEN_W'(MIN_FRAME_LEN);

   // Next frame state and the result of the current byte.
   always_comb begin
      pos_in  = pos_ff;
      len_in  = len_ff;
      xor_in  = xor_ff;
      id_in   = id_ff;
      data_in = data_ff;

      result.valid         = 1'b0;
      result.data.status   = (xor_ff == rx) ? STATUS_GOOD : STATUS_CSUM;
      result.data.can_id   = id_ff;
      result.data.data_len = DLEN_W'(dlen_full);
      result.data.payload  = data_ff;

      if (fire) begin
         priority if (pos_eff == '0) begin
            pos_in = '0;
            if (rx == '0) begin
               // Padding byte: skipped.
               pos_in = '0;
            end else if (len_bad) begin
               result.valid         = 1'b1;
               result.data.status   = STATUS_LEN;
               result.data.can_id   = '0;
               result.data.data_len = '0;
               result.data.payload  = '0;
            end else begin
               len_in  = LEN_W'(rx);
               xor_in  = rx;
               id_in   = '0;
               data_in = '0;
               pos_in  = LEN_W'(1);
            end
         end else if (last_byte) begin
            // Checksum byte closes the frame.
            result.valid = 1'b1;
            pos_in       = '0;
         end else begin
            xor_in = xor_ff ^ rx;
            pos_in = pos_ff + LEN_W'(1);
            if (pos_ff <= LEN_W'(ID_LAST_POS)) begin
               id_in = {id_ff[ID_W-BYTE_W-1:0], rx};
            end
            for (int k = 0; k < LANES; k++) begin
               if (8'(pos_ff) == 8'(DATA_FIRST_POS + k)) begin
                  data_in[k*BYTE_W +: BYTE_W] = rx;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      xor_ff  <= xor_in;
      id_ff   <= id_in;
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

[rtl/core/lxd_rsp_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
module lxd_rsp_reg import lxd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rsp_beat_type result,
   output logic              advance,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  wire logic         rsp_ready
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // The engine may move on whenever this register is free or being drained.
   assign advance  = !valid_ff || rsp_ready;
   assign valid_in = advance ? result.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         data_ff <= result.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

[rtl/core/length_xor_frame_deframer.sv]
// Length-prefixed XOR-checksum deframer. Received bytes enter on req_ch, one item per cycle
// while input is not stalled; each frame (length byte, id high, id low, 0 to 8 data bytes,
// XOR checksum) yields one result on rsp_ch with status, id, data length and packed data. A
// zero length byte is padding, burst_start drops any partial frame, and a length outside 4 to
// 12 gives an immediate length-error result with zero fields. The block sustains one byte per
// cycle: the frame position, running XOR and packing registers sit between the input
// register and the result register. A result is held in the result register and presented on
// rsp_ch until it is taken, and input stalls only while a finished result waits on rsp_ch.
`timescale 1ns / 1ps
`default_nettype none
`include "length_xor_frame_deframer_defines.svh"
module length_xor_frame_deframer import lxd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   lxd_req_if.sink    req_ch,
   lxd_rsp_if.source  rsp_ch
);

   req_type      req_data;
   logic         req_ready;
   req_beat_type beat;
   rsp_beat_type result;
   logic         advance;
   logic         rsp_valid;
   rsp_type      rsp_data;
   logic         rsp_len_err;
   logic         rsp_fields_zero;

   assign req_data.rx_byte     = req_ch.rx_byte;
   assign req_data.burst_start = req_ch.burst_start;
   assign req_ch.ready         = req_ready;

   // Input register.
   lxd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .advance   (advance),
      .beat      (beat)
   );

   // Frame parser and checker.
   lxd_frame_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .beat    (beat),
      .advance (advance),
      .result  (result)
   );

   // Result register.
   lxd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ch.ready)
   );

   assign rsp_ch.valid    = rsp_valid;
   assign rsp_ch.status   = rsp_data.status;
   assign rsp_ch.can_id   = rsp_data.can_id;
   assign rsp_ch.data_len = rsp_data.data_len;
   assign rsp_ch.payload  = rsp_data.payload;

   // Terms for the length error check.
   assign rsp_len_err     = rsp_ch.valid && rsp_ch.status == STATUS_LEN;
   assign rsp_fields_zero = rsp_ch.can_id == '0 && rsp_ch.data_len == '0
                            && rsp_ch.payload == '0;

   // Input stalls only behind a result that is waiting to be taken.
   `LXD_ASSERT_NOW(a_stall_cause, clock, reset, !req_ch.ready, rsp_ch.valid && !rsp_ch.ready)

   // A length error carries no frame contents.
   `LXD_ASSERT_NOW(a_len_err_zero, clock, reset, rsp_len_err, rsp_fields_zero)

   // A result register that is drained and not refilled is empty next cycle.
   `LXD_ASSERT_NEXT(a_drain, clock, reset, rsp_ch.valid && rsp_ch.ready && !result.valid, !rsp_ch.valid)

endmodule
`default_nettype wire
